/* hdl/ptl_pkg.sv */
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types and constants of the paper-tape loader parser.
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int ADDR_BITS = 16;
    localparam int ADDR_W    = (ADDR_BITS < 16) ? ADDR_BITS : 16;
    localparam int WORD_W    = 18;
    localparam int CFG_IDX_W = 1;

    // tape codes
    localparam logic [7:0] FRAME_BINARY = 8'o200;
    localparam logic [7:0] FRAME_STOP   = 8'o377;
    localparam logic [5:0] OP_DIO       = 6'o32;
    localparam logic [5:0] OP_JMP       = 6'o60;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW      = 1'd1;

    typedef enum logic [3:0] {
        EV_RIM_STORE   = 4'd0,
        EV_RIM_END     = 4'd1,
        EV_BLOCK_STORE = 4'd2,
        EV_SUM_GOOD    = 4'd3,
        EV_SUM_BAD     = 4'd4,
        EV_START       = 4'd5,
        EV_PAUSE       = 4'd6,
        EV_STRAY       = 4'd7,
        EV_FORMAT_ERR  = 4'd8,
        EV_PREMATURE   = 4'd9,
        EV_RAW         = 4'd10
    } event_kind_t;

    // word assembler status towards the block parser
    typedef struct packed {
        logic              word_valid;
        logic [WORD_W-1:0] word;
        logic              partial;
        logic              prev_stop;
    } asm_status_t;

    // opcode with the indirect bit ignored
    function automatic logic [5:0] opcode_of(input logic [WORD_W-1:0] w);
        return {w[17:13], 1'b0};
    endfunction

    // 18-bit ones'-complement add with end-around carry
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

/* hdl/ptl_if.sv */
// ----------------------------------------------------------------------------
// ptl_if
// Valid/ready channels for tape frames and parser events.
// ----------------------------------------------------------------------------
interface ptl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tape_char;
    logic       end_of_tape;

    modport source (output valid, output tape_char, output end_of_tape, input ready);
    modport sink   (input valid, input tape_char, input end_of_tape, output ready);
endinterface

interface ptl_out_if
    import ptl_pkg::*;
;
    logic              valid;
    logic              ready;
    event_kind_t       event_kind;
    logic [15:0]       address;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, output event_kind, output address, output data_word,
                    input ready);
    modport sink   (input valid, input event_kind, input address, input data_word,
                    output ready);
endinterface

/* hdl/paper_tape_loader_parser_unit.sv */
// ----------------------------------------------------------------------------
// paper_tape_loader_parser_unit
// RIM / BIN / extended loader tape parser producing load events.
// ----------------------------------------------------------------------------
// An event is registered and appears in the cycle after the frame that completes it.
// Throughput: one frame per cycle unless an event waits; the parser and checksum
// adder settle as the frame is taken, and the event register frees as it is read.
// Reset: assembler, parser, event register and both mode registers clear;
// end of tape restarts assembler and parser but keeps the mode registers.
module paper_tape_loader_parser_unit
    import ptl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    ptl_in_if.sink               tape_in,
    ptl_out_if.source            event_out
);

    typedef enum logic [10:0] {
        PH_START    = 11'b000_0000_0001,
        PH_RESTART  = 11'b000_0000_0010,
        PH_RIMDATA  = 11'b000_0000_0100,
        PH_RIM      = 11'b000_0000_1000,
        PH_LOOKING  = 11'b000_0001_0000,
        PH_HDR2     = 11'b000_0010_0000,
        PH_DATA     = 11'b000_0100_0000,
        PH_SUM      = 11'b000_1000_0000,
        PH_EXTHDR2  = 11'b001_0000_0000,
        PH_STRAY    = 11'b010_0000_0000,
        PH_DONE     = 11'b100_0000_0000
    } phase_t;

    logic              ext_reg, raw_reg;
    phase_t            phase_reg, phase_next;
    logic [ADDR_W-1:0] cur_reg, cur_next, end_reg, end_next, cur_inc;
    logic [WORD_W-1:0] sum_reg, sum_next, w;
    logic [5:0]        op;
    logic [ADDR_W-1:0] rim_addr, ext_addr;

    logic              out_valid_reg;
    event_kind_t       kind_reg, kind_next;
    logic [15:0]       addr_reg, addr_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic              emit;

    logic              accept;
    asm_status_t       asm_st;

    assign tape_in.ready = !out_valid_reg || event_out.ready;
    assign accept        = tape_in.valid && tape_in.ready;

    ptl_word_asm u_asm (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .tape_char   (tape_in.tape_char),
        .end_of_tape (tape_in.end_of_tape),
        .status      (asm_st)
    );

    assign w        = asm_st.word;
    assign op       = opcode_of(w);
    assign rim_addr = ADDR_W'(w[11:0]);
    assign ext_addr = w[ADDR_W-1:0];
    assign cur_inc  = cur_reg + ADDR_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        sum_next   = sum_reg;
        emit       = 1'b0;
        kind_next  = EV_STRAY;
        addr_next  = '0;
        data_next  = '0;
        if (accept && tape_in.end_of_tape)
        begin
            if (asm_st.partial)
            begin
                emit = !asm_st.prev_stop && !raw_reg && phase_reg != PH_STRAY
                       && phase_reg != PH_DONE;
            end
            else
            begin
                emit = !raw_reg && (phase_reg == PH_RIMDATA || phase_reg == PH_HDR2
                       || phase_reg == PH_DATA || phase_reg == PH_SUM
                       || phase_reg == PH_EXTHDR2);
            end
            kind_next  = EV_PREMATURE;
            phase_next = PH_START;
            cur_next   = '0;
            end_next   = '0;
            sum_next   = '0;
        end
        else if (accept && asm_st.word_valid)
        begin
            if (raw_reg)
            begin
                emit      = 1'b1;
                kind_next = EV_RAW;
                data_next = w;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (op == OP_DIO)
                        begin
                            cur_next   = rim_addr;
                            phase_next = PH_RIMDATA;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            kind_next = EV_STRAY;
                            data_next = w;
                        end
                    end
                    PH_RESTART:
                    begin
                        if (op == OP_DIO)
                        begin
                            cur_next   = rim_addr;
                            phase_next = PH_RIMDATA;
                        end
                    end
                    PH_RIMDATA:
                    begin
                        phase_next = PH_RIM;
                        emit       = 1'b1;
                        kind_next  = EV_RIM_STORE;
                        addr_next  = 16'(cur_reg);
                        data_next  = w;
                    end
                    PH_RIM:
                    begin
                        if (op == OP_JMP)
                        begin
                            phase_next = PH_LOOKING;
                            cur_next   = '0;
                            emit       = 1'b1;
                            kind_next  = EV_RIM_END;
                            addr_next  = 16'(rim_addr);
                        end
                        else if (op == OP_DIO)
                        begin
                            cur_next   = rim_addr;
                            phase_next = PH_RIMDATA;
                        end
                        else
                        begin
                            phase_next = PH_STRAY;
                            emit       = 1'b1;
                            kind_next  = EV_FORMAT_ERR;
                            data_next  = w;
                        end
                    end
                    PH_LOOKING:
                    begin
                        if (ext_reg)
                        begin
                            if (w[17:16] != 2'b00)
                            begin
                                // start or pause marker: ignore the rest of the tape
                                phase_next = PH_DONE;
                                emit       = 1'b1;
                                if (w[17:16] == 2'b11)
                                begin
                                    kind_next = EV_PAUSE;
                                end
                                else
                                begin
                                    kind_next = EV_START;
                                    addr_next = 16'(ext_addr);
                                end
                            end
                            else
                            begin
                                cur_next   = ext_addr;
                                phase_next = PH_EXTHDR2;
                            end
                        end
                        else if (op == OP_DIO)
                        begin
                            cur_next   = rim_addr;
                            sum_next   = w;
                            phase_next = PH_HDR2;
                        end
                        else if (op == OP_JMP)
                        begin
                            phase_next = PH_RESTART;
                            emit       = 1'b1;
                            kind_next  = EV_START;
                            addr_next  = 16'(rim_addr);
                        end
                        else
                        begin
                            emit      = 1'b1;
                            kind_next = EV_STRAY;
                            data_next = w;
                        end
                    end
                    PH_HDR2:
                    begin
                        if (op != OP_DIO)
                        begin
                            phase_next = PH_STRAY;
                            emit       = 1'b1;
                            kind_next  = EV_FORMAT_ERR;
                            data_next  = w;
                        end
                        else
                        begin
                            end_next   = rim_addr;
                            sum_next   = ones_add(sum_reg, w);
                            phase_next = PH_DATA;
                        end
                    end
                    PH_EXTHDR2:
                    begin
                        end_next   = ext_addr;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        sum_next  = ones_add(sum_reg, w);
                        cur_next  = cur_inc;
                        emit      = 1'b1;
                        kind_next = EV_BLOCK_STORE;
                        addr_next = 16'(cur_reg);
                        data_next = w;
                        if (cur_inc >= end_reg)
                        begin
                            phase_next = ext_reg ? PH_LOOKING : PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        phase_next = PH_LOOKING;
                        emit       = 1'b1;
                        kind_next  = (w == sum_reg) ? EV_SUM_GOOD : EV_SUM_BAD;
                        data_next  = w;
                    end
                    PH_STRAY:
                    begin
                        emit      = 1'b1;
                        kind_next = EV_STRAY;
                        data_next = w;
                    end
                    PH_DONE:
                    begin
                        // drop everything until end of tape
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg       <= 1'b0;
            raw_reg       <= 1'b0;
            phase_reg     <= PH_START;
            cur_reg       <= '0;
            end_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_EXTENDED: ext_reg <= cfg_data;
                    CFG_RAW:      raw_reg <= cfg_data;
                    default:      ;
                endcase
            end
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            end_reg   <= end_next;
            sum_reg   <= sum_next;
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (event_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // event payload: load only when a new item is launched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= EV_RIM_STORE;
            addr_reg <= '0;
            data_reg <= '0;
        end
        else if (accept && emit)
        begin
            kind_reg <= kind_next;
            addr_reg <= addr_next;
            data_reg <= data_next;
        end
    end

    assign event_out.valid      = out_valid_reg;
    assign event_out.event_kind = kind_reg;
    assign event_out.address    = addr_reg;
    assign event_out.data_word  = data_reg;

endmodule

/* hdl/ptl_word_asm.sv */
// ----------------------------------------------------------------------------
// ptl_word_asm
// Packs the low six bits of three binary frames into one 18-bit word.
// ----------------------------------------------------------------------------
module ptl_word_asm
    import ptl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  tape_char,
    input  logic        end_of_tape,
    output asm_status_t status
);

    logic [WORD_W-1:0] accum_reg, accum_next;
    logic [1:0]        need_reg, need_next;
    logic [7:0]        prev_reg, prev_next;
    logic              binary;

    assign binary = (tape_char & FRAME_BINARY) != 8'd0;

    always_comb
    begin
        accum_next        = accum_reg;
        need_next         = need_reg;
        prev_next         = prev_reg;
        status.word_valid = 1'b0;
        status.word       = {accum_reg[WORD_W-7:0], tape_char[5:0]};
        status.partial    = need_reg != 2'd3;
        status.prev_stop  = prev_reg == FRAME_STOP;
        if (accept)
        begin
            if (end_of_tape)
            begin
                accum_next = '0;
                need_next  = 2'd3;
                prev_next  = '0;
            end
            else if (binary)
            begin
                if (need_reg == 2'd1)
                begin
                    status.word_valid = 1'b1;
                    accum_next        = '0;
                    need_next         = 2'd3;
                    prev_next         = '0;
                end
                else
                begin
                    accum_next = {accum_reg[WORD_W-7:0], tape_char[5:0]};
                    need_next  = need_reg - 2'd1;
                    prev_next  = tape_char;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            need_reg  <= 2'd3;
            prev_reg  <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
            need_reg  <= need_next;
            prev_reg  <= prev_next;
        end
    end

endmodule
